@@ hdl/multi_key_priority_queue_unit_defines.svh @@
// Assertion macros shared by the queue RTL.
`ifndef MULTI_KEY_PRIORITY_QUEUE_UNIT_DEFINES_SVH
`define MULTI_KEY_PRIORITY_QUEUE_UNIT_DEFINES_SVH

// The consequent must hold in the same cycle as the antecedent.
`define MKPQ_ASSERT_SAME(label, clk, rst_n, ante, cons, msg) \
	label: assert property (@(posedge clk) disable iff (!rst_n) (ante) |-> (cons)) \
		else $error(msg);

// The consequent must hold in the cycle after the antecedent.
`define MKPQ_ASSERT_NEXT(label, clk, rst_n, ante, cons, msg) \
	label: assert property (@(posedge clk) disable iff (!rst_n) (ante) |=> (cons)) \
		else $error(msg);

`endif

@@ hdl/mkpq_pkg.sv @@
package mkpq_pkg;

	localparam int QUEUE_DEPTH_DEF = 16;
	localparam int ENTRY_W = 48;

	typedef enum logic [1:0] {
		OP_PUSH   = 2'd0,
		OP_POP    = 2'd1,
		OP_REMOVE = 2'd2,
		OP_NOP    = 2'd3
	} opcode_t;

	typedef enum logic [1:0] {
		ST_OK        = 2'd0,
		ST_FULL      = 2'd1,
		ST_EMPTY     = 2'd2,
		ST_NOT_FOUND = 2'd3
	} status_t;

	typedef struct packed {
		logic [7:0]  prio;
		logic [15:0] arrival;
		logic [15:0] service;
		logic [7:0]  id;
	} entry_t;

	// Higher priority, then earlier arrival, then shorter service, then smaller id.
	function automatic logic goes_before(entry_t a, entry_t b);
		return {a.prio, ~a.arrival, ~a.service, ~a.id} >
			{b.prio, ~b.arrival, ~b.service, ~b.id};
	endfunction

endpackage

@@ hdl/mkpq_req_if.sv @@
interface mkpq_req_if;
	logic        valid;
	logic        ready;
	logic [1:0]  opcode;
	logic [7:0]  item_id;
	logic [15:0] arrival_time;
	logic [15:0] service_time;
	logic [7:0]  priority_req;

	modport source (
		output valid, opcode, item_id, arrival_time, service_time, priority_req,
		input  ready
	);
	modport sink (
		input  valid, opcode, item_id, arrival_time, service_time, priority_req,
		output ready
	);
endinterface

@@ hdl/mkpq_rsp_if.sv @@
interface mkpq_rsp_if;
	logic        valid;
	logic        ready;
	logic [1:0]  status;
	logic [7:0]  head_id;
	logic [15:0] head_arrival;
	logic [15:0] head_service;
	logic [7:0]  head_priority;
	logic [4:0]  occupancy;

	modport source (
		output valid, status, head_id, head_arrival, head_service, head_priority,
			occupancy,
		input  ready
	);
	modport sink (
		input  valid, status, head_id, head_arrival, head_service, head_priority,
			occupancy,
		output ready
	);
endinterface

@@ hdl/mkpq_ram.sv @@
module mkpq_ram #(
	parameter int WIDTH = 8,
	parameter int DEPTH = 16
) (
	input  logic                     clk,
	input  logic                     we,
	input  logic [$clog2(DEPTH)-1:0] waddr,
	input  logic [WIDTH-1:0]         wdata,
	input  logic [$clog2(DEPTH)-1:0] raddr,
	output logic [WIDTH-1:0]         rdata
);

	logic [WIDTH-1:0] mem [DEPTH];

	always_ff @(posedge clk) begin
		if (we) begin
			mem[waddr] <= wdata;
		end
		rdata <= mem[raddr];
	end

endmodule

@@ hdl/multi_key_priority_queue_unit.sv @@
// Channel  Modport  Word
// req      sink     opcode, item_id, arrival_time, service_time, priority_req
// rsp      source   status, head_id, head_arrival, head_service, head_priority, occupancy
//
// A push, pop or remove walks the entry RAM through its single read port, one entry at a time.
// Push visits the entries behind the insertion point, from the tail towards the head, and
// shifts each one back; pop and remove visit every occupied entry; a dropped push,
// an empty pop or opcode 3 visit none and go straight to the reply.
// The request side is not ready while an operation is in progress.
// A result waits in the output register, so the next request is taken while it is stalled.
// Reset clears the occupancy; the entry RAM needs no clearing.
module multi_key_priority_queue_unit
	import mkpq_pkg::*;
#(
	parameter int QUEUE_DEPTH = QUEUE_DEPTH_DEF
) (
	input  logic             clk,
	input  logic             arst_n,
	mkpq_req_if.sink         req,
	mkpq_rsp_if.source       rsp
);

`include "multi_key_priority_queue_unit_defines.svh"

	localparam int IDX_W = $clog2(QUEUE_DEPTH);
	localparam int CNT_W = $clog2(QUEUE_DEPTH + 1);
	localparam logic [CNT_W-1:0] DEPTH_C = CNT_W'(QUEUE_DEPTH);

	typedef enum logic [1:0] {
		S_IDLE,
		S_RD,
		S_EV,
		S_DONE
	} state_t;

	state_t           state_q;
	opcode_t          op_q;
	entry_t           new_q;
	entry_t           head_q;
	status_t          status_q;
	logic             found_q;
	logic [CNT_W-1:0] p_q;
	logic [CNT_W-1:0] count_q;

	logic             out_valid_q;
	status_t          out_status_q;
	entry_t           out_head_q;
	logic [4:0]       out_occ_q;

	logic [CNT_W-1:0] p_dec;
	logic [IDX_W-1:0] rd_idx;
	logic             we;
	logic [IDX_W-1:0] waddr;
	entry_t           wdata;
	logic [ENTRY_W-1:0] rdata;
	entry_t           rd_entry;
	logic             new_first;
	logic             match;

	assign p_dec     = p_q - CNT_W'(1);
	assign rd_idx    = (op_q == OP_PUSH) ? p_dec[IDX_W-1:0] : p_q[IDX_W-1:0];
	assign rd_entry  = entry_t'(rdata);
	assign new_first = goes_before(new_q, rd_entry);
	assign match     = (op_q == OP_POP) ? (p_q == '0) : (rd_entry.id == new_q.id);

	always_comb begin
		we    = 1'b0;
		waddr = p_q[IDX_W-1:0];
		wdata = new_q;
		case (state_q)
			S_RD: begin
				if (op_q == OP_PUSH && p_q == '0) begin
					we = 1'b1;
				end
			end
			S_EV: begin
				if (op_q == OP_PUSH) begin
					we    = 1'b1;
					wdata = new_first ? rd_entry : new_q;
				end else begin
					we    = found_q;
					waddr = p_dec[IDX_W-1:0];
					wdata = rd_entry;
				end
			end
			default: begin
				we = 1'b0;
			end
		endcase
	end

	mkpq_ram #(
		.WIDTH (ENTRY_W),
		.DEPTH (QUEUE_DEPTH)
	) u_ram (
		.clk   (clk),
		.we    (we),
		.waddr (waddr),
		.wdata (ENTRY_W'(wdata)),
		.raddr (rd_idx),
		.rdata (rdata)
	);

	assign req.ready = (state_q == S_IDLE);

	always_ff @(posedge clk or negedge arst_n) begin
		if (!arst_n) begin
			state_q      <= S_IDLE;
			op_q         <= OP_NOP;
			new_q        <= '0;
			head_q       <= '0;
			status_q     <= ST_OK;
			found_q      <= 1'b0;
			p_q          <= '0;
			count_q      <= '0;
			out_valid_q  <= 1'b0;
			out_status_q <= ST_OK;
			out_head_q   <= '0;
			out_occ_q    <= '0;
		end else begin
			if (rsp.ready && state_q != S_DONE) begin
				out_valid_q <= 1'b0;
			end
			case (state_q)
				S_IDLE: begin
					if (req.valid) begin
						op_q          <= opcode_t'(req.opcode);
						new_q.prio    <= req.priority_req;
						new_q.arrival <= req.arrival_time;
						new_q.service <= req.service_time;
						new_q.id      <= req.item_id;
						head_q        <= '0;
						found_q       <= 1'b0;
						status_q      <= ST_OK;
						p_q           <= '0;
						case (opcode_t'(req.opcode))
							OP_PUSH: begin
								if (count_q == DEPTH_C) begin
									status_q <= ST_FULL;
									state_q  <= S_DONE;
								end else begin
									p_q     <= count_q;
									state_q <= S_RD;
								end
							end
							OP_POP: begin
								if (count_q == '0) begin
									status_q <= ST_EMPTY;
									state_q  <= S_DONE;
								end else begin
									state_q <= S_RD;
								end
							end
							OP_REMOVE: begin
								state_q <= S_RD;
							end
							default: begin
								state_q <= S_DONE;
							end
						endcase
					end
				end
				S_RD: begin
					if (op_q == OP_PUSH) begin
						if (p_q == '0) begin
							count_q <= count_q + CNT_W'(1);
							state_q <= S_DONE;
						end else begin
							state_q <= S_EV;
						end
					end else if (p_q == count_q) begin
						if (found_q) begin
							count_q <= count_q - CNT_W'(1);
						end else begin
							status_q <= ST_NOT_FOUND;
						end
						state_q <= S_DONE;
					end else begin
						state_q <= S_EV;
					end
				end
				S_EV: begin
					if (op_q == OP_PUSH) begin
						if (new_first) begin
							p_q     <= p_dec;
							state_q <= S_RD;
						end else begin
							count_q <= count_q + CNT_W'(1);
							state_q <= S_DONE;
						end
					end else begin
						if (!found_q && match) begin
							found_q <= 1'b1;
							if (op_q == OP_POP) begin
								head_q <= rd_entry;
							end
						end
						p_q     <= p_q + CNT_W'(1);
						state_q <= S_RD;
					end
				end
				S_DONE: begin
					if (!out_valid_q || rsp.ready) begin
						out_valid_q  <= 1'b1;
						out_status_q <= status_q;
						out_head_q   <= head_q;
						out_occ_q    <= 5'(count_q);
						state_q      <= S_IDLE;
					end
				end
				default: begin
					state_q <= S_IDLE;
				end
			endcase
		end
	end

	assign rsp.valid         = out_valid_q;
	assign rsp.status        = out_status_q;
	assign rsp.head_id       = out_head_q.id;
	assign rsp.head_arrival  = out_head_q.arrival;
	assign rsp.head_service  = out_head_q.service;
	assign rsp.head_priority = out_head_q.prio;
	assign rsp.occupancy     = out_occ_q;

	`MKPQ_ASSERT_SAME(a_count_in_range, clk, arst_n, 1'b1, count_q <= DEPTH_C, "occupancy above depth")
	`MKPQ_ASSERT_SAME(a_write_in_walk, clk, arst_n, we, (state_q == S_RD) || (state_q == S_EV), "RAM write outside a walk")
	`MKPQ_ASSERT_SAME(a_full_reply, clk, arst_n, rsp.valid && (rsp.status == ST_FULL), (rsp.occupancy == 5'(DEPTH_C)) && (rsp.head_id == 8'd0), "bad full reply")
	`MKPQ_ASSERT_NEXT(a_busy_after_accept, clk, arst_n, req.valid && req.ready, !req.ready, "request taken twice")

endmodule
